// ===== design/rid_pkg.sv =====
`default_nettype none

package rid_pkg;

  // Width of every operand and result field on the ports.
  localparam int FIELD_W = 64;

  // Default operand width used inside the divider.
  localparam int WIDTH_DEF = 64;

  typedef struct packed {
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] quotient;
    logic [FIELD_W-1:0] remainder;
  } out_t;

endpackage

`default_nettype wire

// ===== design/rid_cell.sv =====
`default_nettype none

module rid_cell #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] rem_i,
  input  logic [WIDTH-1:0] nq_i,
  input  logic [WIDTH-1:0] d_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rem_o,
  output logic [WIDTH-1:0] nq_o,
  output logic [WIDTH-1:0] d_o
);

  // One restoring step. The nq word holds the dividend bits still to enter
  // at the top and the quotient bits found so far at the bottom.
  logic             valid_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] rem_nxt;
  logic [WIDTH-1:0] nq_r;
  logic [WIDTH-1:0] nq_nxt;
  logic [WIDTH-1:0] d_r;
  logic [WIDTH:0]   shifted;
  logic [WIDTH+1:0] diff;
  logic             ge;

  always_comb begin
    shifted = {rem_i, nq_i[WIDTH-1]};
    diff    = {1'b0, shifted} - {2'b00, d_i};
    ge      = ~diff[WIDTH+1];
    rem_nxt = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    nq_nxt  = {nq_i[WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    nq_r  <= nq_nxt;
    d_r   <= d_i;
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign nq_o    = nq_r;
  assign d_o     = d_r;

endmodule

`default_nettype wire

// ===== design/restoring_integer_divider.sv =====
`default_nettype none

// Channel   Ports                      Transfer
// --------  -------------------------  ------------------------------------
// input     start, busy, in_data       start high and busy low at a clk edge
// result    out_valid, out_data        out_valid high for one cycle, taken
//
// Every result passes through the operand register and then through each of
// the WIDTH division cells. A new operand pair may be transferred in every
// cycle while busy is low. Reset (rst_n low, synchronous) empties the cell
// chain; busy is registered, set while rst_n is low and cleared once rst_n is
// sampled high. The receiver cannot stall the results.
module restoring_integer_divider #(
  parameter int WIDTH = rid_pkg::WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  rid_pkg::in_t in_data,
  output logic         out_valid,
  output rid_pkg::out_t out_data
);

  import rid_pkg::*;

  // The busy flag only covers the reset period, so no transfer is taken
  // while the chain is being cleared.
  logic busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // Operand register at the head of the chain. Only the low WIDTH bits of
  // each operand take part. Equal operands, zero over zero included, are
  // replaced by one over one, which the plain algorithm turns into quotient
  // one and remainder zero. Every other case, a zero divisor too, comes out
  // of the restoring steps directly.
  logic             in_xfer;
  logic [WIDTH-1:0] n_in;
  logic [WIDTH-1:0] d_in;
  logic             eq_in;
  logic             valid0_r;
  logic [WIDTH-1:0] nq0_r;
  logic [WIDTH-1:0] d0_r;

  assign in_xfer = start & ~busy_r;
  assign n_in    = in_data.dividend[WIDTH-1:0];
  assign d_in    = in_data.divisor[WIDTH-1:0];
  assign eq_in   = (n_in == d_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= 1'b0;
    end else begin
      valid0_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    nq0_r <= eq_in ? WIDTH'(1) : n_in;
    d0_r  <= eq_in ? WIDTH'(1) : d_in;
  end

  // The chain: cell k performs the step for dividend bit WIDTH-1-k. Each
  // cell hands its partial remainder, shifted dividend/quotient word and
  // divisor to the next one in every cycle.
  logic             valid_s [0:WIDTH];
  logic [WIDTH-1:0] rem_s   [0:WIDTH];
  logic [WIDTH-1:0] nq_s    [0:WIDTH];
  logic [WIDTH-1:0] d_s     [0:WIDTH];

  assign valid_s[0] = valid0_r;
  assign rem_s[0]   = '0;
  assign nq_s[0]    = nq0_r;
  assign d_s[0]     = d0_r;

  for (genvar k = 0; k < WIDTH; k++) begin : g_cell
    rid_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .valid_i(valid_s[k]),
      .rem_i  (rem_s[k]),
      .nq_i   (nq_s[k]),
      .d_i    (d_s[k]),
      .valid_o(valid_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .nq_o   (nq_s[k+1]),
      .d_o    (d_s[k+1])
    );
  end

  // After the last cell every dividend bit has been shifted out, so the
  // whole word is the quotient. Results are zero-extended to the port width.
  assign out_valid          = valid_s[WIDTH];
  assign out_data.quotient  = FIELD_W'(nq_s[WIDTH]);
  assign out_data.remainder = FIELD_W'(rem_s[WIDTH]);

  // Each input transfer yields a result once it has passed the operand register and every cell.
  a_latency_fwd : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> ##(WIDTH+1) out_valid)
    else $error("result missing after input transfer");

  // No result without an input transfer at the matching cycle.
  a_latency_bwd : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_xfer, WIDTH+1))
    else $error("result without input transfer");

  // With a nonzero divisor the remainder stays below it.
  a_rem_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (d_s[WIDTH] != '0) |-> (rem_s[WIDTH] < d_s[WIDTH]))
    else $error("remainder not below divisor");

  // A zero divisor only reaches the chain with a nonzero dividend, which
  // gives an all-ones quotient.
  a_zero_div : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (d_s[WIDTH] == '0) |-> (nq_s[WIDTH] == '1))
    else $error("zero divisor without all-ones quotient");

endmodule

`default_nettype wire
